// ----- design/bdist_pkg.sv -----
// Shared types, codes and saturation helper for the boundary distance block.
`default_nettype none

package bdist_pkg;

    localparam int DATA_W = 32;
    localparam int FACE_W = 7;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;
    localparam logic signed [FACE_W-1:0] FACE_NONE = -7'sd1;

    // Request codes carried in tuser.
    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_SET  = 2'd1,
        MODE_DIST = 2'd2,
        MODE_NEAR = 2'd3
    } t_mode;

    // Primitive kinds held by a cell.
    typedef enum logic [1:0] {
        KIND_EMPTY = 2'd0,
        KIND_PLANE = 2'd1,
        KIND_BORE  = 2'd2,
        KIND_SLAB  = 2'd3
    } t_kind;

    // Kind and face id of one table slot.
    typedef struct packed {
        t_kind                     kind;
        logic signed [FACE_W-1:0] face;
    } t_prim_hdr;

    // Answer of the term unit for one primitive.
    typedef struct packed {
        logic                      done;
        logic signed [DATA_W-1:0] term;
    } t_term_rsp;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [DATA_W-1:0] y;
        if (x > SAT_MAX) begin
            y = 32'sh7FFF_FFFF;
        end else if (x < SAT_MIN) begin
            y = 32'sh8000_0000;
        end else begin
            y = x[DATA_W-1:0];
        end
        return y;
    endfunction

endpackage

`default_nettype wire

// ----- design/bdist_isqrt.sv -----
// Integer square root of a 64-bit value, one result bit per cycle.
`default_nettype none

module bdist_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_value,
    output logic             o_done,
    output logic [31:0]      o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic [63:0] trial;

    assign trial = r_r + r_bit;

    // Control: busy flag, iteration count and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: restoring root, two radicand bits per step.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_r   <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[31:0];

endmodule

`default_nettype wire

// ----- design/bdist_cell.sv -----
// One table slot of the primitive ring: kind, face id and geometry words.
`default_nettype none

module bdist_cell #(
    parameter int WORDS_PER_ENTRY = 32,
    parameter int WIDX_W          = 5
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_shift,
    input  wire bdist_pkg::t_prim_hdr            i_hdr,
    input  wire logic [WORDS_PER_ENTRY*32-1:0]   i_words,
    input  wire logic                            i_word_we,
    input  wire logic [WIDX_W-1:0]               i_widx,
    input  wire logic [31:0]                     i_wvalue,
    input  wire logic                            i_hdr_we,
    input  wire bdist_pkg::t_prim_hdr            i_hdr_new,
    output bdist_pkg::t_prim_hdr                 o_hdr,
    output logic [WORDS_PER_ENTRY*32-1:0]        o_words
);

    bdist_pkg::t_prim_hdr                r_hdr;
    logic [WORDS_PER_ENTRY-1:0][31:0]    r_words;

    // Kind and face: cleared to empty and no face at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr.kind <= bdist_pkg::KIND_EMPTY;
            r_hdr.face <= bdist_pkg::FACE_NONE;
        end else if (i_shift) begin
            r_hdr <= i_hdr;
        end else if (i_hdr_we) begin
            r_hdr <= i_hdr_new;
        end
    end

    // Geometry words move with the ring or take a single loaded word.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_words <= i_words;
        end else if (i_word_we) begin
            r_words[i_widx] <= i_wvalue;
        end
    end

    assign o_hdr   = r_hdr;
    assign o_words = r_words;

endmodule

`default_nettype wire

// ----- design/bdist_term.sv -----
// Term unit: signed allowed-region term of one primitive on a shared multiplier.
`default_nettype none

module bdist_term #(
    parameter int WORDS_PER_ENTRY = 32,
    parameter int FRAC_BITS       = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire bdist_pkg::t_kind              i_kind,
    input  wire logic [WORDS_PER_ENTRY*32-1:0] i_words,
    input  wire logic signed [31:0]            i_px,
    input  wire logic signed [31:0]            i_py,
    input  wire logic signed [31:0]            i_pz,
    output bdist_pkg::t_term_rsp               o_rsp
);

    localparam int WIDX_W = $clog2(WORDS_PER_ENTRY);
    localparam int MW     = 35;
    localparam logic signed [MW-1:0] M_BIG = {1'b0, {(MW-1){1'b1}}};
    localparam logic signed [MW-1:0] C_MAX = MW'(64'sd2147483647);

    typedef enum logic [13:0] {
        E_IDLE = 14'h0001,
        E_DIFF = 14'h0002,
        E_DMUL = 14'h0004,
        E_DACC = 14'h0008,
        E_RMUL = 14'h0010,
        E_RSUB = 14'h0020,
        E_RSQ  = 14'h0040,
        E_RACC = 14'h0080,
        E_SQS  = 14'h0100,
        E_SQW  = 14'h0200,
        E_MARG = 14'h0400,
        E_CMUL = 14'h0800,
        E_CACC = 14'h1000,
        E_DONE = 14'h2000
    } t_estate;

    t_estate             r_state;
    bdist_pkg::t_kind    r_kind;
    logic signed [31:0]  r_d    [3];
    logic signed [31:0]  r_proj [3];
    logic signed [31:0]  r_c    [3];
    logic [1:0]          r_j;
    logic [1:0]          r_q;
    logic signed [63:0]  r_acc;
    logic signed [63:0]  r_prod;
    logic signed [31:0]  r_rr;
    logic [63:0]         r_sq;
    logic                r_second;
    logic [31:0]         r_rho;
    logic signed [31:0]  r_term;

    logic signed [31:0]  w [WORDS_PER_ENTRY];
    logic [WIDX_W-1:0]   widx;
    logic signed [31:0]  mul_a;
    logic signed [31:0]  mul_b;
    logic signed [63:0]  prod_sh;
    logic signed [63:0]  acc_new;
    logic [63:0]         sq_new;
    logic signed [MW-1:0] m [3];
    logic signed [MW-1:0] m_min;
    logic                all_in;
    logic                sq_done;
    logic [31:0]         sq_root;

    // Word view of the head slot.
    for (genvar k = 0; k < WORDS_PER_ENTRY; k++) begin : g_word
        assign w[k] = i_words[k*32 +: 32];
    end

    assign prod_sh = r_prod >>> FRAC_BITS;
    assign acc_new = r_acc + prod_sh;
    assign sq_new  = r_sq + $unsigned(r_prod);

    // Multiplier operand selection.
    always_comb begin
        widx  = WIDX_W'(3) + WIDX_W'(r_q) * WIDX_W'(3) + WIDX_W'(r_j);
        mul_a = r_rr;
        mul_b = r_rr;
        case (r_state)
            E_DMUL: begin
                mul_a = r_d[r_j];
                mul_b = w[widx];
            end
            E_RMUL: begin
                mul_a = w[WIDX_W'(3) + WIDX_W'(r_j)];
                mul_b = r_proj[0];
            end
            E_CMUL: begin
                mul_a = r_c[r_j];
                mul_b = r_c[r_j];
            end
            default: begin
                mul_a = r_rr;
                mul_b = r_rr;
            end
        endcase
    end

    // Margins of a keep-out: radial and axial for a bore, three slabs for a box.
    always_comb begin
        logic signed [MW-1:0] lo;
        logic signed [MW-1:0] hi;
        logic signed [MW-1:0] lo2;
        logic signed [MW-1:0] hi2;
        logic signed [MW-1:0] lo3;
        logic signed [MW-1:0] hi3;
        lo  = '0;
        hi  = '0;
        lo2 = '0;
        hi2 = '0;
        lo3 = '0;
        hi3 = '0;
        if (r_kind == bdist_pkg::KIND_BORE) begin
            lo   = MW'(r_proj[0]) - MW'(w[7]);
            hi   = MW'(w[8]) - MW'(r_proj[0]);
            m[0] = MW'(w[6]) - $signed({3'b000, r_rho});
            m[1] = (lo < hi) ? lo : hi;
            m[2] = M_BIG;
        end else begin
            lo   = MW'(r_proj[0]);
            hi   = MW'(w[12]) - MW'(r_proj[0]);
            lo2  = MW'(r_proj[1]) - MW'(w[13]);
            hi2  = MW'(w[14]) - MW'(r_proj[1]);
            lo3  = MW'(r_proj[2]) - MW'(w[15]);
            hi3  = MW'(w[16]) - MW'(r_proj[2]);
            m[0] = (lo < hi) ? lo : hi;
            m[1] = (lo2 < hi2) ? lo2 : hi2;
            m[2] = (lo3 < hi3) ? lo3 : hi3;
        end
        m_min  = (m[0] < m[1]) ? m[0] : m[1];
        m_min  = (m[2] < m_min) ? m[2] : m_min;
        all_in = !m[0][MW-1] && !m[1][MW-1] && !m[2][MW-1];
    end

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
        end else begin
            case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        r_state <= E_DIFF;
                    end
                end
                E_DIFF: r_state <= E_DMUL;
                E_DMUL: r_state <= E_DACC;
                E_DACC: begin
                    if (r_j != 2'd2) begin
                        r_state <= E_DMUL;
                    end else if (r_kind == bdist_pkg::KIND_PLANE) begin
                        r_state <= E_DONE;
                    end else if (r_kind == bdist_pkg::KIND_BORE) begin
                        r_state <= E_RMUL;
                    end else if (r_q != 2'd2) begin
                        r_state <= E_DMUL;
                    end else begin
                        r_state <= E_MARG;
                    end
                end
                E_RMUL: r_state <= E_RSUB;
                E_RSUB: r_state <= E_RSQ;
                E_RSQ:  r_state <= E_RACC;
                E_RACC: r_state <= (r_j != 2'd2) ? E_RMUL : E_SQS;
                E_SQS:  r_state <= E_SQW;
                E_SQW: begin
                    if (sq_done) begin
                        r_state <= r_second ? E_DONE : E_MARG;
                    end
                end
                E_MARG: r_state <= all_in ? E_DONE : E_CMUL;
                E_CMUL: r_state <= E_CACC;
                E_CACC: r_state <= (r_j != 2'd2) ? E_CMUL : E_SQS;
                E_DONE: r_state <= E_IDLE;
                default: r_state <= E_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            E_IDLE: begin
                r_kind   <= i_kind;
                r_j      <= '0;
                r_q      <= '0;
                r_acc    <= '0;
                r_sq     <= '0;
                r_second <= 1'b0;
            end
            E_DIFF: begin
                r_d[0] <= bdist_pkg::sat32(64'(i_px) - 64'(w[0]));
                r_d[1] <= bdist_pkg::sat32(64'(i_py) - 64'(w[1]));
                r_d[2] <= bdist_pkg::sat32(64'(i_pz) - 64'(w[2]));
            end
            E_DACC: begin
                if (r_j != 2'd2) begin
                    r_acc <= acc_new;
                    r_j   <= r_j + 2'd1;
                end else begin
                    r_acc        <= '0;
                    r_j          <= '0;
                    r_q          <= r_q + 2'd1;
                    r_proj[r_q]  <= bdist_pkg::sat32(acc_new);
                    r_term       <= bdist_pkg::sat32(-acc_new);
                end
            end
            E_RSUB: begin
                r_rr <= bdist_pkg::sat32(64'(r_d[r_j]) - prod_sh);
            end
            E_RACC, E_CACC: begin
                r_sq <= sq_new;
                r_j  <= (r_j != 2'd2) ? r_j + 2'd1 : 2'd0;
            end
            E_SQW: begin
                if (sq_done) begin
                    r_rho  <= sq_root;
                    r_term <= bdist_pkg::sat32({32'd0, sq_root});
                end
            end
            E_MARG: begin
                r_term   <= bdist_pkg::sat32(-64'(m_min));
                r_sq     <= '0;
                r_j      <= '0;
                r_second <= 1'b1;
                for (int k = 0; k < 3; k++) begin
                    if (!m[k][MW-1]) begin
                        r_c[k] <= '0;
                    end else if (-m[k] > C_MAX) begin
                        r_c[k] <= 32'sh7FFF_FFFF;
                    end else begin
                        r_c[k] <= 32'(-m[k]);
                    end
                end
            end
            default: begin
                r_j <= r_j;
            end
        endcase
    end

    bdist_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == E_SQS),
        .i_value (r_sq),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign o_rsp.done = (r_state == E_DONE);
    assign o_rsp.term = r_term;

endmodule

`default_nettype wire

// ----- design/boundary_signed_distance_eval.sv -----
// Top level: primitive ring, shared term unit and query scan control.
// Operation: a load writes its slot on acceptance; a query scans every slot once per pass,
// runs the term unit on each eligible one, and posts the result from the hold state.
// Throughput: one item at a time; loads every cycle while idle; a query's pace is set by
// the shared multiplier and the one-bit-per-cycle square root (nearest-face: two passes).
// Reset: synchronous active low; all slots become empty with no face, no result pending.
`default_nettype none

module boundary_signed_distance_eval #(
    parameter int ENTRIES         = 16,
    parameter int WORDS_PER_ENTRY = 32,
    parameter int FRAC_BITS       = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // entry, word_index, word_value, prim_kind_in, face_in, px, py, pz, exclude_a, exclude_b
    input  wire logic [159:0] i_s_axis_tdata,
    // mode
    input  wire logic [1:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // distance, nearest, zero fill
    output logic [39:0]       o_m_axis_tdata
);

    localparam int WIDX_W = $clog2(WORDS_PER_ENTRY);
    localparam int WBITS  = WORDS_PER_ENTRY * 32;
    localparam int CNT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_EVAL = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state                    r_state;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_pass;
    logic                      r_near;
    logic signed [31:0]        r_px;
    logic signed [31:0]        r_py;
    logic signed [31:0]        r_pz;
    logic signed [6:0]         r_exa;
    logic signed [6:0]         r_exb;
    logic signed [31:0]        r_best;
    logic                      r_found;
    logic signed [6:0]         r_bface;
    logic                      r_out_valid;
    logic [39:0]               r_out_data;

    bdist_pkg::t_mode          in_mode;
    logic [3:0]                in_entry;
    logic [4:0]                in_widx;
    logic [31:0]               in_wvalue;
    bdist_pkg::t_prim_hdr      in_hdr;
    logic                      accept;
    logic                      word_ok;
    logic                      shift;
    logic                      eligible;
    logic                      excluded;
    logic                      last;
    bdist_pkg::t_term_rsp      rsp;
    bdist_pkg::t_prim_hdr      hdr_q   [ENTRIES];
    logic [WBITS-1:0]          words_q [ENTRIES];

    // Request fields.
    assign in_mode     = bdist_pkg::t_mode'(i_s_axis_tuser);
    assign in_entry    = i_s_axis_tdata[3:0];
    assign in_widx     = i_s_axis_tdata[8:4];
    assign in_wvalue   = i_s_axis_tdata[40:9];
    assign in_hdr.kind = bdist_pkg::t_kind'(i_s_axis_tdata[42:41]);
    assign in_hdr.face = i_s_axis_tdata[49:43];
    assign accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign word_ok     = 32'(in_widx) < WORDS_PER_ENTRY;

    // Ring of slots; slot 0 is the head seen by the term unit.
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        bdist_cell #(
            .WORDS_PER_ENTRY (WORDS_PER_ENTRY),
            .WIDX_W          (WIDX_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (shift),
            .i_hdr     (hdr_q[(i + 1) % ENTRIES]),
            .i_words   (words_q[(i + 1) % ENTRIES]),
            .i_word_we (accept && in_mode == bdist_pkg::MODE_LOAD && word_ok
                        && 32'(in_entry) == i),
            .i_widx    (WIDX_W'(in_widx)),
            .i_wvalue  (in_wvalue),
            .i_hdr_we  (accept && in_mode == bdist_pkg::MODE_SET && 32'(in_entry) == i),
            .i_hdr_new (in_hdr),
            .o_hdr     (hdr_q[i]),
            .o_words   (words_q[i])
        );
    end

    bdist_term #(
        .WORDS_PER_ENTRY (WORDS_PER_ENTRY),
        .FRAC_BITS       (FRAC_BITS)
    ) u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SCAN && eligible),
        .i_kind  (hdr_q[0].kind),
        .i_words (words_q[0]),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_pz    (r_pz),
        .o_rsp   (rsp)
    );

    // Head slot selection: planes first on a nearest-face pass, exclusions on distance.
    assign excluded = !hdr_q[0].face[6] && (hdr_q[0].face == r_exa || hdr_q[0].face == r_exb);
    assign eligible = (hdr_q[0].kind != bdist_pkg::KIND_EMPTY)
                   && (r_near ? (r_pass == (hdr_q[0].kind != bdist_pkg::KIND_PLANE))
                              : !excluded);
    assign shift    = (r_state == S_SCAN && !eligible) || (r_state == S_EVAL && rsp.done);
    assign last     = (r_cnt == CNT_W'(ENTRIES - 1));

    // Scan control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The output slot is filled from the hold state and emptied when taken.
            if (r_state == S_HOLD && (!r_out_valid || i_m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && (in_mode == bdist_pkg::MODE_DIST
                                   || in_mode == bdist_pkg::MODE_NEAR)) begin
                        r_state <= S_SCAN;
                        r_cnt   <= '0;
                        r_pass  <= 1'b0;
                    end
                end
                S_SCAN, S_EVAL: begin
                    if (r_state == S_SCAN && eligible) begin
                        r_state <= S_EVAL;
                    end else if (shift) begin
                        if (!last) begin
                            r_cnt   <= r_cnt + CNT_W'(1);
                            r_state <= S_SCAN;
                        end else if (r_near && !r_pass) begin
                            r_cnt   <= '0;
                            r_pass  <= 1'b1;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Query operands and running best.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept) begin
            r_near  <= (in_mode == bdist_pkg::MODE_NEAR);
            r_px    <= i_s_axis_tdata[81:50];
            r_py    <= i_s_axis_tdata[113:82];
            r_pz    <= i_s_axis_tdata[145:114];
            r_exa   <= i_s_axis_tdata[152:146];
            r_exb   <= i_s_axis_tdata[159:153];
            r_best  <= 32'sh7FFF_FFFF;
            r_found <= 1'b0;
            r_bface <= bdist_pkg::FACE_NONE;
        end else if (r_state == S_EVAL && rsp.done) begin
            if (r_near) begin
                if (!r_found || rsp.term < r_best) begin
                    r_best  <= rsp.term;
                    r_bface <= hdr_q[0].face;
                    r_found <= 1'b1;
                end
            end else if (rsp.term < r_best) begin
                r_best <= rsp.term;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (r_state == S_HOLD && (!r_out_valid || i_m_axis_tready)) begin
            r_out_data <= {1'b0,
                           r_near ? r_bface : bdist_pkg::FACE_NONE,
                           r_near ? 32'sd0 : r_best};
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// ----- design/bdist_chk.sv -----
// Port-level checker for the boundary distance block, bound to the top level.
`default_nettype none

module bdist_chk (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic [159:0] i_s_axis_tdata,
    input wire logic [1:0]   i_s_axis_tuser,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [39:0]  o_m_axis_tdata
);

    // A pending result stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result withdrawn before it was taken");

    // Reset leaves no result pending.
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result pending after reset");

    // An accepted query occupies the block on the next cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready
        && (i_s_axis_tuser == bdist_pkg::MODE_DIST || i_s_axis_tuser == bdist_pkg::MODE_NEAR)
        |=> !o_s_axis_tready)
        else $error("query did not occupy the block");

    // Table writes complete at once and leave the block free.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready
        && (i_s_axis_tuser == bdist_pkg::MODE_LOAD || i_s_axis_tuser == bdist_pkg::MODE_SET)
        |=> o_s_axis_tready)
        else $error("table write stalled the block");

    // A distance result carries no face id; a nearest-face result carries zero distance.
    a_field_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[38:32] == 7'h7F || o_m_axis_tdata[31:0] == 32'd0))
        else $error("result fields inconsistent");

endmodule

bind boundary_signed_distance_eval bdist_chk u_bdist_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

// ----- tb/tb_boundary_signed_distance_eval.sv -----
// Self-checking testbench for the boundary signed-distance evaluator.
`timescale 1ns / 100ps
`default_nettype none

module tb_boundary_signed_distance_eval;

    localparam int NSLOT    = 16;
    localparam int NWORD    = 32;
    localparam int FRAC     = 16;
    localparam int IDLE_MAX = 20000;
    localparam int ITEMS    = 700;
    localparam int UNIT     = 65536;

    // One request as seen on the slave stream.
    typedef struct {
        bdist_pkg::t_mode        mode;
        logic [3:0]              entry;
        logic [4:0]              widx;
        logic signed [31:0]      wval;
        bdist_pkg::t_kind        kind;
        logic signed [6:0]       face;
        logic signed [31:0]      px;
        logic signed [31:0]      py;
        logic signed [31:0]      pz;
        logic signed [6:0]       exa;
        logic signed [6:0]       exb;
    } t_request;

    // One answer expected on the master stream.
    typedef struct {
        logic signed [31:0] distance;
        logic signed [6:0]  nearest;
    } t_answer;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [159:0] i_s_axis_tdata;
    logic [1:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [39:0]  o_m_axis_tdata;

    // Shadow copy of the primitive table.
    logic signed [31:0] geo_words [NSLOT][NWORD];
    bit                 geo_written [NSLOT][NWORD];
    bdist_pkg::t_kind   slot_kind [NSLOT];
    logic signed [6:0]  slot_face [NSLOT];

    t_answer answers_due[$];
    int      error_count;
    int      requests_sent;
    int      idle_cycles = 0;
    int      burst_left;
    int      stall_phase = 0;

    boundary_signed_distance_eval uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint clip32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint clip_out(input longint x);
        if (x < 0) return 0;
        return clip32(x);
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint gw(input int e, input int k);
        longint v;
        v = longint'(geo_words[e][k]);
        return v;
    endfunction

    // Fixed-point dot of a difference vector with three words of a slot.
    function automatic longint project(input longint d[3], input int e, input int k);
        longint s;
        s = 0;
        for (int i = 0; i < 3; i++) s += (d[i] * gw(e, k + i)) >>> FRAC;
        return s;
    endfunction

    // Signed distance term of one slot, saturated to 32 bits.
    function automatic longint slot_term(input int e, input longint p[3]);
        longint d[3];
        longint t, r, drad, dax, ko, a, b, c, s, u, w, ds, du, dw;
        longint unsigned sq;
        for (int i = 0; i < 3; i++) d[i] = clip32(p[i] - gw(e, i));
        if (slot_kind[e] == bdist_pkg::KIND_PLANE) return clip32(-project(d, e, 3));
        if (slot_kind[e] == bdist_pkg::KIND_BORE) begin
            t  = clip32(project(d, e, 3));
            sq = 0;
            for (int i = 0; i < 3; i++) begin
                r  = clip32(d[i] - ((gw(e, 3 + i) * t) >>> FRAC));
                sq += longint'(r * r);
            end
            drad = gw(e, 6) - longint'(floor_root(sq));
            dax  = t - gw(e, 7);
            if (gw(e, 8) - t < dax) dax = gw(e, 8) - t;
            if (drad >= 0 && dax >= 0) begin
                ko = (drad < dax) ? drad : dax;
            end else begin
                a  = clip_out(-drad);
                b  = clip_out(-dax);
                ko = -longint'(floor_root(a * a + b * b));
            end
            return clip32(-ko);
        end
        s  = clip32(project(d, e, 3));
        u  = clip32(project(d, e, 6));
        w  = clip32(project(d, e, 9));
        ds = (s < gw(e, 12) - s) ? s : gw(e, 12) - s;
        du = (u - gw(e, 13) < gw(e, 14) - u) ? u - gw(e, 13) : gw(e, 14) - u;
        dw = (w - gw(e, 15) < gw(e, 16) - w) ? w - gw(e, 15) : gw(e, 16) - w;
        if (ds >= 0 && du >= 0 && dw >= 0) begin
            ko = ds;
            if (du < ko) ko = du;
            if (dw < ko) ko = dw;
        end else begin
            a  = clip_out(-ds);
            b  = clip_out(-du);
            c  = clip_out(-dw);
            ko = -longint'(floor_root(a * a + b * b + c * c));
        end
        return clip32(-ko);
    endfunction

    // Apply one accepted request to the shadow table and queue its answer.
    function automatic void predict_request(input t_request q);
        longint  p[3];
        longint  best, tv;
        t_answer ans;
        p[0] = q.px;
        p[1] = q.py;
        p[2] = q.pz;
        case (q.mode)
            bdist_pkg::MODE_LOAD: begin
                geo_words[q.entry][q.widx]   = q.wval;
                geo_written[q.entry][q.widx] = 1'b1;
            end
            bdist_pkg::MODE_SET: begin
                slot_kind[q.entry] = q.kind;
                slot_face[q.entry] = q.face;
            end
            bdist_pkg::MODE_DIST: begin
                best = 64'sd2147483647;
                for (int e = 0; e < NSLOT; e++) begin
                    if (slot_kind[e] == bdist_pkg::KIND_EMPTY) continue;
                    if (slot_face[e] >= 0 && (slot_face[e] == q.exa || slot_face[e] == q.exb))
                        continue;
                    tv = slot_term(e, p);
                    if (tv < best) best = tv;
                end
                ans.distance = best[31:0];
                ans.nearest  = bdist_pkg::FACE_NONE;
                answers_due  = {answers_due, ans};
            end
            default: begin
                // Planes are visited before keep-outs; only a strictly smaller term wins.
                best = 64'h7FFF_FFFF_FFFF_FFFF;
                ans.distance = '0;
                ans.nearest  = bdist_pkg::FACE_NONE;
                for (int pass = 0; pass < 2; pass++) begin
                    for (int e = 0; e < NSLOT; e++) begin
                        if (slot_kind[e] == bdist_pkg::KIND_EMPTY) continue;
                        if ((pass == 0) != (slot_kind[e] == bdist_pkg::KIND_PLANE)) continue;
                        tv = slot_term(e, p);
                        if (tv < best) begin
                            best        = tv;
                            ans.nearest = slot_face[e];
                        end
                    end
                end
                answers_due = {answers_due, ans};
            end
        endcase
    endfunction

    // ------------------------------------------------------------------ driving

    // Send one request and hold it until the block takes it.
    task automatic send_request(input t_request q);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= q.mode;
        i_s_axis_tdata  <= {q.exb, q.exa, q.pz, q.py, q.px, q.face, q.kind,
                            q.wval, q.widx, q.entry};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_request(q);
        requests_sent++;
        // Bursts of back-to-back requests separated by random gaps.
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    function automatic t_request blank_request(input bdist_pkg::t_mode m);
        t_request q;
        q.mode  = m;
        q.entry = 4'($urandom);
        q.widx  = 5'($urandom);
        q.wval  = $urandom;
        q.kind  = bdist_pkg::t_kind'($urandom_range(0, 3));
        q.face  = 7'($urandom_range(0, 64) - 1);
        q.px    = $urandom;
        q.py    = $urandom;
        q.pz    = $urandom;
        q.exa   = 7'($urandom_range(0, 64) - 1);
        q.exb   = 7'($urandom_range(0, 64) - 1);
        return q;
    endfunction

    function automatic logic signed [31:0] rand_span(input int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // A coordinate: mostly within a work volume, sometimes anywhere.
    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return rand_span(200 * UNIT);
    endfunction

    task automatic load_word(input int e, input int k, input logic signed [31:0] v);
        t_request q;
        q       = blank_request(bdist_pkg::MODE_LOAD);
        q.entry = 4'(e);
        q.widx  = 5'(k);
        q.wval  = v;
        send_request(q);
    endtask

    task automatic set_slot(input int e, input bdist_pkg::t_kind kd,
                            input logic signed [6:0] f);
        t_request q;
        q       = blank_request(bdist_pkg::MODE_SET);
        q.entry = 4'(e);
        q.kind  = kd;
        q.face  = f;
        send_request(q);
    endtask

    task automatic query(input bdist_pkg::t_mode m, input logic signed [31:0] x,
                         input logic signed [31:0] y, input logic signed [31:0] z,
                         input logic signed [6:0] ea, input logic signed [6:0] eb);
        t_request q;
        q     = blank_request(m);
        q.px  = x;
        q.py  = y;
        q.pz  = z;
        q.exa = ea;
        q.exb = eb;
        send_request(q);
    endtask

    // Write all geometry of a primitive with random content, then declare it.
    task automatic build_primitive(input int e, input bdist_pkg::t_kind kd,
                                   input logic signed [6:0] f);
        int n;
        n = (kd == bdist_pkg::KIND_PLANE) ? 6 : (kd == bdist_pkg::KIND_BORE) ? 9 : 17;
        for (int k = 0; k < n; k++) begin
            if (k < 3)
                load_word(e, k, rand_coord());
            else if (k < 12)
                load_word(e, k, rand_span(UNIT));
            else
                load_word(e, k, rand_span(60 * UNIT));
        end
        set_slot(e, kd, f);
    endtask

    function automatic bit geometry_ready(input int e, input bdist_pkg::t_kind kd);
        int n;
        n = (kd == bdist_pkg::KIND_PLANE) ? 6 : (kd == bdist_pkg::KIND_BORE) ? 9 :
            (kd == bdist_pkg::KIND_SLAB) ? 17 : 0;
        for (int k = 0; k < n; k++) if (!geo_written[e][k]) return 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------- tests

    // An empty table saturates the distance and reports no face.
    task automatic test_empty_table();
        query(bdist_pkg::MODE_DIST, 0, 0, 0, bdist_pkg::FACE_NONE, bdist_pkg::FACE_NONE);
        query(bdist_pkg::MODE_NEAR, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 7'sd63, 7'sd0);
    endtask

    // Two identical planes: ties keep the lower slot, exclusion skips by face.
    task automatic test_planes_and_ties();
        for (int s = 0; s < 2; s++) begin
            load_word(s, 0, 0);
            load_word(s, 1, 0);
            load_word(s, 2, 0);
            load_word(s, 3, 0);
            load_word(s, 4, 0);
            load_word(s, 5, UNIT);
        end
        set_slot(0, bdist_pkg::KIND_PLANE, 7'sd5);
        set_slot(1, bdist_pkg::KIND_PLANE, 7'sd63);
        query(bdist_pkg::MODE_NEAR, 0, 0, -UNIT, bdist_pkg::FACE_NONE, bdist_pkg::FACE_NONE);
        query(bdist_pkg::MODE_DIST, 0, 0, -UNIT, 7'sd5, bdist_pkg::FACE_NONE);
        query(bdist_pkg::MODE_DIST, 0, 0, 32'sh8000_0000, 7'sd5, 7'sd63);
        query(bdist_pkg::MODE_DIST, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              bdist_pkg::FACE_NONE, 7'sd63);
    endtask

    // A bore with a face of none that no exclusion can skip, and a slab with face 1.
    task automatic test_keepouts();
        build_primitive(14, bdist_pkg::KIND_BORE, bdist_pkg::FACE_NONE);
        build_primitive(15, bdist_pkg::KIND_SLAB, 7'sd1);
        query(bdist_pkg::MODE_DIST, 0, 0, 0, bdist_pkg::FACE_NONE, bdist_pkg::FACE_NONE);
        query(bdist_pkg::MODE_NEAR, rand_coord(), rand_coord(), rand_coord(), 7'sd1, 7'sd5);
        query(bdist_pkg::MODE_DIST, 32'sh8000_0000, 32'sh7FFF_FFFF, 0,
              bdist_pkg::FACE_NONE, 7'sd1);
    endtask

    // Mostly whole primitives and queries, with stray writes and slot changes.
    task automatic test_random_traffic();
        int               pick, e;
        bdist_pkg::t_kind kd;
        while (requests_sent < ITEMS) begin
            pick = $urandom_range(0, 99);
            e    = $urandom_range(0, NSLOT - 1);
            if (pick < 15) begin
                build_primitive(e, bdist_pkg::t_kind'($urandom_range(1, 3)),
                                7'($urandom_range(0, 64) - 1));
            end else if (pick < 25) begin
                load_word(e, $urandom_range(0, NWORD - 1), $urandom);
            end else if (pick < 32) begin
                kd = bdist_pkg::t_kind'($urandom_range(0, 3));
                if (!geometry_ready(e, kd)) kd = bdist_pkg::KIND_EMPTY;
                set_slot(e, kd, 7'($urandom_range(0, 64) - 1));
            end else begin
                query(($urandom_range(0, 1) != 0) ? bdist_pkg::MODE_DIST : bdist_pkg::MODE_NEAR,
                      rand_coord(), rand_coord(), rand_coord(),
                      ($urandom_range(0, 2) == 0) ? slot_face[e]
                                                  : 7'($urandom_range(0, 64) - 1),
                      7'($urandom_range(0, 64) - 1));
            end
        end
    endtask

    // ----------------------------------------------------------------- checking

    // Receiver stall pattern steps through four modes chosen by bits 10:9 of the phase counter.
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        case (stall_phase[10:9])
            2'd0:    i_m_axis_tready <= 1'b1;
            2'd1:    i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    i_m_axis_tready <= (stall_phase[2:0] != 3'd0);
            default: i_m_axis_tready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    // Compare every accepted answer with the oldest one due.
    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected answer %h", $time, o_m_axis_tdata);
                error_count++;
            end else begin
                exp_ans = answers_due.pop_front();
                if (o_m_axis_tdata[31:0] !== exp_ans.distance) begin
                    $display("%0t: distance expected %0d actual %0d", $time,
                             exp_ans.distance, $signed(o_m_axis_tdata[31:0]));
                    error_count++;
                end
                if (o_m_axis_tdata[38:32] !== exp_ans.nearest) begin
                    $display("%0t: nearest expected %0d actual %0d", $time,
                             exp_ans.nearest, $signed(o_m_axis_tdata[38:32]));
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no request or answer accepted.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("tb_boundary_signed_distance_eval: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------ sequence

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        error_count     = 0;
        requests_sent   = 0;
        burst_left      = 0;
        for (int e = 0; e < NSLOT; e++) begin
            slot_kind[e] = bdist_pkg::KIND_EMPTY;
            slot_face[e] = bdist_pkg::FACE_NONE;
            for (int k = 0; k < NWORD; k++) begin
                geo_words[e][k]   = '0;
                geo_written[e][k] = 1'b0;
            end
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_planes_and_ties();
        test_keepouts();
        test_random_traffic();

        i_s_axis_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_boundary_signed_distance_eval: clean");
        else
            $display("tb_boundary_signed_distance_eval: errors");
        $finish;
    end

endmodule

`default_nettype wire
